[hdl/lsfj_pkg.sv]
// Package for the launcher spin-up, feed and jam sequencer.
// Holds beat payload types, state codes, register indexes and reset values.
// No dependencies.
package lsfj_pkg;

    // Flywheel machine codes
    localparam logic [1:0] WHEEL_IDLE   = 2'd0;
    localparam logic [1:0] WHEEL_SHOOT  = 2'd1;
    localparam logic [1:0] WHEEL_RUNOUT = 2'd2;

    // Feeder machine codes
    localparam logic [2:0] FEED_STANDBY  = 3'd0;
    localparam logic [2:0] FEED_SPINUP   = 3'd1;
    localparam logic [2:0] FEED_FIRING   = 3'd2;
    localparam logic [2:0] FEED_JAM      = 3'd3;
    localparam logic [2:0] FEED_OVERHEAT = 3'd4;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_UNJAM_SPEED    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_MARGIN   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BALANCE_MARGIN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_JAM_TORQUE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_JAM_SPEED      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_UNJAM_MS       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_MS       = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_HEAT_RESUME    = 3'd7;

    // Register reset values
    localparam logic signed [15:0] RST_UNJAM_SPEED    = 16'sd0;
    localparam logic [14:0]        RST_SPEED_MARGIN   = 15'd100;
    localparam logic [14:0]        RST_BALANCE_MARGIN = 15'd100;
    localparam logic [14:0]        RST_JAM_TORQUE     = 15'd5000;
    localparam logic [14:0]        RST_JAM_SPEED      = 15'd50;
    localparam logic [15:0]        RST_UNJAM_MS       = 16'd200;
    localparam logic [15:0]        RST_CLEAR_MS       = 16'd500;
    localparam logic [15:0]        RST_HEAT_RESUME    = 16'd2;

    // Input beat
    typedef struct packed {
        logic               enable;
        logic               fire;
        logic               keep_spinning;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic signed [15:0] feed_rpm;
        logic signed [15:0] feeder_torque;
        logic [15:0]        shots_left;
        logic [31:0]        now_ms;
        logic [14:0]        wheel_target;
        logic signed [15:0] feed_target;
    } item_t;

    // Result beat
    typedef struct packed {
        logic signed [15:0] left_setpoint;
        logic signed [15:0] right_setpoint;
        logic signed [15:0] feeder_setpoint;
        logic [1:0]         wheel_state;
        logic [2:0]         feed_state;
        logic               clear_integral;
    } result_t;

    // Magnitude of a 17-bit signed value; -65536 comes out as 65536
    function automatic logic [16:0] mag17(input logic signed [16:0] v);
        logic [16:0] r;
        r = v[16] ? 17'(-v) : 17'(v);
        return r;
    endfunction

endpackage

[hdl/launcher_spinup_feed_jam_sequencer_core.sv]
// Top level of the launcher spin-up, feed and jam sequencer.
// Depends on lsfj_pkg for payload types, state codes and register indexes.
//
// Usage:
//   Each input beat on item_data is one control tick. It is taken when
//   item_valid and item_ready are both high; its result beat appears on
//   result_data with result_valid in the next cycle and stays until
//   result_ready is high. One result beat per input beat, in order.
//   Throughput is one beat per cycle: both machines step in a single
//   combinational pass from the input port into the result register,
//   so item_ready stays high while the result register is empty or is
//   being emptied in the same cycle. A stalled receiver holds the result
//   register and drops item_ready until it is taken.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data),
//   taken at once; write only while no beat is in flight.
//   Reset (rst_n low, asynchronous) puts both machines in standby, clears
//   the stored start times, empties the result register and loads the
//   default register values.
module launcher_spinup_feed_jam_sequencer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  lsfj_pkg::item_t                     item_data,
    output logic                                result_valid,
    input  logic                                result_ready,
    output lsfj_pkg::result_t                   result_data,
    input  logic                                cfg_we,
    input  logic [lsfj_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lsfj_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers
    logic signed [15:0] unjam_speed_reg;
    logic [14:0]        speed_margin_reg;
    logic [14:0]        balance_margin_reg;
    logic [14:0]        jam_torque_reg;
    logic [14:0]        jam_speed_reg;
    logic [15:0]        unjam_ms_reg;
    logic [15:0]        clear_ms_reg;
    logic [15:0]        heat_resume_reg;

    // Machine state
    logic [1:0]  wheel_mode_reg, wheel_mode_next;
    logic [2:0]  feed_mode_reg, feed_mode_next;
    logic [31:0] clear_start_reg, clear_start_next;
    logic [31:0] jam_start_reg, jam_start_next;

    // Result register
    logic              result_valid_reg;
    lsfj_pkg::result_t result_data_reg, result_data_next;

    logic accept;

    // Wheel and feeder measurements
    logic signed [16:0] wheel_sum;
    logic signed [16:0] wheel_diff;
    logic [16:0]        imbalance;
    logic [16:0]        diff_mag;
    logic [15:0]        avg_speed;
    logic signed [16:0] speed_err_s;
    logic [16:0]        speed_err;
    logic [16:0]        feeder_mag;
    logic signed [16:0] torque_x;
    logic signed [16:0] jam_torque_pos;
    logic signed [16:0] jam_torque_neg;
    logic [31:0]        clear_elapsed;
    logic [31:0]        jam_elapsed;
    logic               speed_ok;
    logic               speed_bad;
    logic               jam_hit;
    logic               clr_pulse;

    assign item_ready   = !result_valid_reg || result_ready;
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    // Derive errors and jam conditions from the incoming beat
    always_comb
    begin
        wheel_sum      = 17'(item_data.left_speed) + 17'(item_data.right_speed);
        wheel_diff     = 17'(item_data.left_speed) - 17'(item_data.right_speed);
        imbalance      = lsfj_pkg::mag17(wheel_sum);
        diff_mag       = lsfj_pkg::mag17(wheel_diff);
        avg_speed      = diff_mag[16:1];
        speed_err_s    = signed'({1'b0, avg_speed}) - signed'({2'b00, item_data.wheel_target});
        speed_err      = lsfj_pkg::mag17(speed_err_s);
        feeder_mag     = lsfj_pkg::mag17(17'(item_data.feed_rpm));
        torque_x       = 17'(item_data.feeder_torque);
        jam_torque_pos = signed'({2'b00, jam_torque_reg});
        jam_torque_neg = -jam_torque_pos;
        clear_elapsed  = item_data.now_ms - clear_start_reg;
        jam_elapsed    = item_data.now_ms - jam_start_reg;
        speed_ok       = (speed_err < {2'b00, speed_margin_reg})
                      && (imbalance < {2'b00, balance_margin_reg});
        speed_bad      = (speed_err > {2'b00, speed_margin_reg})
                      && (imbalance > {2'b00, balance_margin_reg});
        jam_hit        = (torque_x > jam_torque_pos)
                      && (feeder_mag < {2'b00, jam_speed_reg});
    end

    // Step the flywheel machine; it sees the feeder mode before this tick
    always_comb
    begin
        wheel_mode_next  = wheel_mode_reg;
        clear_start_next = clear_start_reg;
        case (wheel_mode_reg)
            lsfj_pkg::WHEEL_IDLE:
            begin
                if (item_data.keep_spinning || item_data.fire)
                    wheel_mode_next = lsfj_pkg::WHEEL_SHOOT;
            end
            lsfj_pkg::WHEEL_SHOOT:
            begin
                if (!item_data.fire && !item_data.keep_spinning)
                begin
                    wheel_mode_next  = lsfj_pkg::WHEEL_RUNOUT;
                    clear_start_next = item_data.now_ms;
                end
            end
            lsfj_pkg::WHEEL_RUNOUT:
            begin
                if (item_data.fire)
                    wheel_mode_next = lsfj_pkg::WHEEL_SHOOT;
                else if ((clear_elapsed > {16'd0, clear_ms_reg})
                      && (feed_mode_reg == lsfj_pkg::FEED_STANDBY))
                    wheel_mode_next = lsfj_pkg::WHEEL_IDLE;
            end
            default:
            begin
                wheel_mode_next = lsfj_pkg::WHEEL_IDLE;
            end
        endcase
    end

    // Step the feeder machine
    always_comb
    begin
        feed_mode_next = feed_mode_reg;
        jam_start_next = jam_start_reg;
        clr_pulse      = 1'b0;
        case (feed_mode_reg)
            lsfj_pkg::FEED_STANDBY:
            begin
                if (item_data.fire)
                    feed_mode_next = lsfj_pkg::FEED_SPINUP;
            end
            lsfj_pkg::FEED_SPINUP:
            begin
                if (speed_ok)
                    feed_mode_next = lsfj_pkg::FEED_FIRING;
            end
            lsfj_pkg::FEED_FIRING:
            begin
                if (jam_hit)
                begin
                    jam_start_next = item_data.now_ms;
                    clr_pulse      = 1'b1;
                    feed_mode_next = lsfj_pkg::FEED_JAM;
                end
                else if (!item_data.fire)
                    feed_mode_next = lsfj_pkg::FEED_STANDBY;
                else if (item_data.shots_left == 16'd0)
                    feed_mode_next = lsfj_pkg::FEED_OVERHEAT;
                else if (speed_bad)
                    feed_mode_next = lsfj_pkg::FEED_SPINUP;
            end
            lsfj_pkg::FEED_JAM:
            begin
                if ((jam_elapsed > {16'd0, unjam_ms_reg}) || (torque_x < jam_torque_neg))
                    feed_mode_next = lsfj_pkg::FEED_SPINUP;
            end
            lsfj_pkg::FEED_OVERHEAT:
            begin
                if (item_data.shots_left > heat_resume_reg)
                    feed_mode_next = item_data.fire ? lsfj_pkg::FEED_SPINUP
                                                    : lsfj_pkg::FEED_STANDBY;
            end
            default:
            begin
                feed_mode_next = lsfj_pkg::FEED_STANDBY;
            end
        endcase
    end

    // Form the result beat; hold modes and zero setpoints when disabled
    always_comb
    begin
        result_data_next = '0;
        if (item_data.enable)
        begin
            result_data_next.wheel_state    = wheel_mode_next;
            result_data_next.feed_state     = feed_mode_next;
            result_data_next.clear_integral = clr_pulse;
            if ((wheel_mode_next == lsfj_pkg::WHEEL_SHOOT)
             || (wheel_mode_next == lsfj_pkg::WHEEL_RUNOUT))
            begin
                result_data_next.left_setpoint  = signed'({1'b0, item_data.wheel_target});
                result_data_next.right_setpoint = 16'sd0 - signed'({1'b0, item_data.wheel_target});
            end
            if (feed_mode_next == lsfj_pkg::FEED_FIRING)
                result_data_next.feeder_setpoint = item_data.feed_target;
            else if (feed_mode_next == lsfj_pkg::FEED_JAM)
                result_data_next.feeder_setpoint = unjam_speed_reg;
        end
        else
        begin
            result_data_next.wheel_state = wheel_mode_reg;
            result_data_next.feed_state  = feed_mode_reg;
        end
    end

    // Advance machine state on an enabled beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_mode_reg  <= lsfj_pkg::WHEEL_IDLE;
            feed_mode_reg   <= lsfj_pkg::FEED_STANDBY;
            clear_start_reg <= '0;
            jam_start_reg   <= '0;
        end
        else if (accept && item_data.enable)
        begin
            wheel_mode_reg  <= wheel_mode_next;
            feed_mode_reg   <= feed_mode_next;
            clear_start_reg <= clear_start_next;
            jam_start_reg   <= jam_start_next;
        end
    end

    // Hold the result beat until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (accept)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_data_reg <= result_data_next;
    end

    // Configuration writes; unused upper data bits drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unjam_speed_reg    <= lsfj_pkg::RST_UNJAM_SPEED;
            speed_margin_reg   <= lsfj_pkg::RST_SPEED_MARGIN;
            balance_margin_reg <= lsfj_pkg::RST_BALANCE_MARGIN;
            jam_torque_reg     <= lsfj_pkg::RST_JAM_TORQUE;
            jam_speed_reg      <= lsfj_pkg::RST_JAM_SPEED;
            unjam_ms_reg       <= lsfj_pkg::RST_UNJAM_MS;
            clear_ms_reg       <= lsfj_pkg::RST_CLEAR_MS;
            heat_resume_reg    <= lsfj_pkg::RST_HEAT_RESUME;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lsfj_pkg::REG_UNJAM_SPEED:    unjam_speed_reg    <= signed'(cfg_data);
                lsfj_pkg::REG_SPEED_MARGIN:   speed_margin_reg   <= cfg_data[14:0];
                lsfj_pkg::REG_BALANCE_MARGIN: balance_margin_reg <= cfg_data[14:0];
                lsfj_pkg::REG_JAM_TORQUE:     jam_torque_reg     <= cfg_data[14:0];
                lsfj_pkg::REG_JAM_SPEED:      jam_speed_reg      <= cfg_data[14:0];
                lsfj_pkg::REG_UNJAM_MS:       unjam_ms_reg       <= cfg_data;
                lsfj_pkg::REG_CLEAR_MS:       clear_ms_reg       <= cfg_data;
                lsfj_pkg::REG_HEAT_RESUME:    heat_resume_reg    <= cfg_data;
                default:                      ;
            endcase
        end
    end

endmodule

[tb/sv/launcher_spinup_feed_jam_sequencer_core_test.sv]
// Self-checking testbench for launcher_spinup_feed_jam_sequencer_core.
// Drives control ticks over valid/ready and checks every result beat against
// an in-bench model of both machines. Depends on lsfj_pkg and the core.
module launcher_spinup_feed_jam_sequencer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_ready;
    lsfj_pkg::item_t   item_data = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    lsfj_pkg::result_t result_data;
    logic              cfg_we = 1'b0;
    logic [lsfj_pkg::CFG_INDEX_W-1:0] cfg_index = lsfj_pkg::REG_UNJAM_SPEED;
    logic [lsfj_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    launcher_spinup_feed_jam_sequencer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Register copies held by the model
    logic signed [15:0] unjam_setpoint = lsfj_pkg::RST_UNJAM_SPEED;
    int speed_tol         = int'(lsfj_pkg::RST_SPEED_MARGIN);
    int balance_tol       = int'(lsfj_pkg::RST_BALANCE_MARGIN);
    int jam_torque_lim    = int'(lsfj_pkg::RST_JAM_TORQUE);
    int jam_speed_lim     = int'(lsfj_pkg::RST_JAM_SPEED);
    int unjam_hold_ms     = int'(lsfj_pkg::RST_UNJAM_MS);
    int clear_hold_ms     = int'(lsfj_pkg::RST_CLEAR_MS);
    int heat_resume_shots = int'(lsfj_pkg::RST_HEAT_RESUME);

    // Machine state held by the model
    logic [1:0]  wheel_mode_q = lsfj_pkg::WHEEL_IDLE;
    logic [2:0]  feed_mode_q  = lsfj_pkg::FEED_STANDBY;
    logic [31:0] clear_t0     = '0;
    logic [31:0] jam_t0       = '0;

    lsfj_pkg::result_t due_setpoints[$];

    int n_errors    = 0;
    int n_ticks     = 0;
    int n_checked   = 0;
    int n_jams      = 0;
    int n_overheat  = 0;
    int n_settings  = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic        fire_hold  = 1'b0;
    logic [31:0] tick_clock = 32'hFFFF_F000;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int abs_int(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Step both machines for one tick and return the setpoints it yields
    function automatic lsfj_pkg::result_t step_launcher(input lsfj_pkg::item_t it);
        lsfj_pkg::result_t r;
        logic [2:0]  prior_feed;
        logic [31:0] elapsed;
        int          imbalance;
        int          avg;
        int          err;
        int          tgt;
        int          ftq;
        r = '0;
        if (it.enable)
        begin
            prior_feed = feed_mode_q;
            tgt        = int'(it.wheel_target);
            ftq        = int'($signed(it.feeder_torque));
            imbalance  = abs_int(int'($signed(it.left_speed)) + int'($signed(it.right_speed)));
            avg        = abs_int(int'($signed(it.left_speed)) - int'($signed(it.right_speed))) / 2;
            err        = abs_int(avg - tgt);

            // Flywheel machine sees the feeder mode from before this tick
            case (wheel_mode_q)
                lsfj_pkg::WHEEL_IDLE:
                    if (it.keep_spinning || it.fire)
                        wheel_mode_q = lsfj_pkg::WHEEL_SHOOT;
                lsfj_pkg::WHEEL_SHOOT:
                    if (!it.fire && !it.keep_spinning)
                    begin
                        wheel_mode_q = lsfj_pkg::WHEEL_RUNOUT;
                        clear_t0     = it.now_ms;
                    end
                lsfj_pkg::WHEEL_RUNOUT:
                begin
                    elapsed = it.now_ms - clear_t0;
                    if (it.fire)
                        wheel_mode_q = lsfj_pkg::WHEEL_SHOOT;
                    else if (elapsed > 32'(clear_hold_ms)
                             && prior_feed == lsfj_pkg::FEED_STANDBY)
                        wheel_mode_q = lsfj_pkg::WHEEL_IDLE;
                end
                default:
                    wheel_mode_q = lsfj_pkg::WHEEL_IDLE;
            endcase

            // Feeder machine
            case (feed_mode_q)
                lsfj_pkg::FEED_STANDBY:
                    if (it.fire)
                        feed_mode_q = lsfj_pkg::FEED_SPINUP;
                lsfj_pkg::FEED_SPINUP:
                    if (err < speed_tol && imbalance < balance_tol)
                        feed_mode_q = lsfj_pkg::FEED_FIRING;
                lsfj_pkg::FEED_FIRING:
                    if (ftq > jam_torque_lim
                        && abs_int(int'($signed(it.feed_rpm))) < jam_speed_lim)
                    begin
                        jam_t0           = it.now_ms;
                        r.clear_integral = 1'b1;
                        feed_mode_q      = lsfj_pkg::FEED_JAM;
                    end
                    else if (!it.fire)
                        feed_mode_q = lsfj_pkg::FEED_STANDBY;
                    else if (it.shots_left == 16'd0)
                        feed_mode_q = lsfj_pkg::FEED_OVERHEAT;
                    else if (err > speed_tol && imbalance > balance_tol)
                        feed_mode_q = lsfj_pkg::FEED_SPINUP;
                lsfj_pkg::FEED_JAM:
                begin
                    elapsed = it.now_ms - jam_t0;
                    if (elapsed > 32'(unjam_hold_ms) || ftq < -jam_torque_lim)
                        feed_mode_q = lsfj_pkg::FEED_SPINUP;
                end
                lsfj_pkg::FEED_OVERHEAT:
                    if (int'(it.shots_left) > heat_resume_shots)
                        feed_mode_q = it.fire ? lsfj_pkg::FEED_SPINUP : lsfj_pkg::FEED_STANDBY;
                default:
                    feed_mode_q = lsfj_pkg::FEED_STANDBY;
            endcase

            if (wheel_mode_q == lsfj_pkg::WHEEL_SHOOT || wheel_mode_q == lsfj_pkg::WHEEL_RUNOUT)
            begin
                r.left_setpoint  = 16'(tgt);
                r.right_setpoint = 16'(-tgt);
            end
            if (feed_mode_q == lsfj_pkg::FEED_FIRING)
                r.feeder_setpoint = it.feed_target;
            else if (feed_mode_q == lsfj_pkg::FEED_JAM)
                r.feeder_setpoint = unjam_setpoint;
        end
        r.wheel_state = wheel_mode_q;
        r.feed_state  = feed_mode_q;
        return r;
    endfunction

    function automatic lsfj_pkg::item_t tick(input logic en, input logic fire, input logic keep,
                                             input int l, input int r, input int fs,
                                             input int ft, input int shots,
                                             input logic [31:0] now,
                                             input int tgt, input int ftg);
        lsfj_pkg::item_t it;
        it.enable        = en;
        it.fire          = fire;
        it.keep_spinning = keep;
        it.left_speed    = 16'(l);
        it.right_speed   = 16'(r);
        it.feed_rpm      = 16'(fs);
        it.feeder_torque = 16'(ft);
        it.shots_left    = 16'(shots);
        it.now_ms        = now;
        it.wheel_target  = 15'(tgt);
        it.feed_target   = 16'(ftg);
        return it;
    endfunction

    // Present one beat, idling first at random, and log its expected result
    task automatic send_beat(input lsfj_pkg::item_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        due_setpoints.push_back(step_launcher(it));
        n_ticks++;
    endtask

    // Drop valid and hold until every expected result has been taken
    task automatic wait_results_settled();
        @(negedge clk);
        item_valid <= 1'b0;
        while (due_setpoints.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lsfj_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            lsfj_pkg::REG_UNJAM_SPEED:    unjam_setpoint    = data;
            lsfj_pkg::REG_SPEED_MARGIN:   speed_tol         = int'(data[14:0]);
            lsfj_pkg::REG_BALANCE_MARGIN: balance_tol       = int'(data[14:0]);
            lsfj_pkg::REG_JAM_TORQUE:     jam_torque_lim    = int'(data[14:0]);
            lsfj_pkg::REG_JAM_SPEED:      jam_speed_lim     = int'(data[14:0]);
            lsfj_pkg::REG_UNJAM_MS:       unjam_hold_ms     = int'(data);
            lsfj_pkg::REG_CLEAR_MS:       clear_hold_ms     = int'(data);
            lsfj_pkg::REG_HEAT_RESUME:    heat_resume_shots = int'(data);
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [15:0] unjam_spd, input logic [15:0] spd_tol,
                                input logic [15:0] bal_tol, input logic [15:0] jam_tq,
                                input logic [15:0] jam_spd, input logic [15:0] unjam_t,
                                input logic [15:0] clear_t, input logic [15:0] heat_res);
        write_reg(lsfj_pkg::REG_UNJAM_SPEED, unjam_spd);
        write_reg(lsfj_pkg::REG_SPEED_MARGIN, spd_tol);
        write_reg(lsfj_pkg::REG_BALANCE_MARGIN, bal_tol);
        write_reg(lsfj_pkg::REG_JAM_TORQUE, jam_tq);
        write_reg(lsfj_pkg::REG_JAM_SPEED, jam_spd);
        write_reg(lsfj_pkg::REG_UNJAM_MS, unjam_t);
        write_reg(lsfj_pkg::REG_CLEAR_MS, clear_t);
        write_reg(lsfj_pkg::REG_HEAT_RESUME, heat_res);
        @(negedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Random ticks shaped to walk both machines through spin-up, jams and overheat
    task automatic run_random_ticks(input int count, input int send_idle,
                                    input int recv_stall, input bit pause_midway);
        lsfj_pkg::item_t it;
        int    tgt;
        int    jt;
        int    hr;
        int    roll;
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                wait_results_settled();

            it.enable = ($urandom_range(99) < 95);
            if ($urandom_range(99) < 8)
                fire_hold = !fire_hold;
            it.fire          = ($urandom_range(99) < 4) ? !fire_hold : fire_hold;
            it.keep_spinning = ($urandom_range(99) < 12);
            it.wheel_target  = 15'($urandom);
            tgt = int'(it.wheel_target);

            // Mostly balanced wheels near target so spin-up can complete
            if ($urandom_range(99) < 70)
            begin
                it.left_speed  = 16'(tgt + int'($urandom_range(300)) - 150);
                it.right_speed = 16'(-tgt + int'($urandom_range(300)) - 150);
            end
            else
            begin
                it.left_speed  = 16'($urandom);
                it.right_speed = 16'($urandom);
            end

            if ($urandom_range(99) < 30)
                it.feed_rpm = 16'(int'($urandom_range(200)) - 100);
            else
                it.feed_rpm = 16'($urandom);

            // Torque around the jam thresholds
            jt   = jam_torque_lim;
            roll = int'($urandom_range(99));
            if (roll < 25 && jt < 32767)
                it.feeder_torque = 16'(jt + 1 + int'($urandom_range(32766 - jt)));
            else if (roll < 35 && jt < 32767)
                it.feeder_torque = 16'(-(jt + 1 + int'($urandom_range(32767 - jt))));
            else if (roll < 40)
                it.feeder_torque = ($urandom_range(1) != 0) ? 16'(jt) : 16'(-jt);
            else
                it.feeder_torque = 16'($urandom);

            roll = int'($urandom_range(99));
            if (roll < 10)
                it.shots_left = '0;
            else if (roll < 30)
            begin
                hr = heat_resume_shots + int'($urandom_range(3)) - 1;
                if (hr < 0)
                    hr = 0;
                if (hr > 65535)
                    hr = 65535;
                it.shots_left = 16'(hr);
            end
            else
                it.shots_left = 16'($urandom);

            // Advance time; mostly short steps, now and then a jump
            roll = int'($urandom_range(99));
            if (roll < 80)
                tick_clock = tick_clock + $urandom_range(40);
            else if (roll < 92)
                tick_clock = tick_clock + $urandom_range(1000);
            else if (roll < 97)
                tick_clock = tick_clock + $urandom_range(70000);
            else
                tick_clock = $urandom;
            it.now_ms = tick_clock;

            it.feed_target = 16'($urandom);
            send_beat(it);
        end
        wait_results_settled();
    endtask

    // Walk every transition, threshold and special case by hand
    task automatic test_directed_sequences();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        program_regs(16'(-1234), 16'd100, 16'd100, 16'd5000, 16'd50, 16'd200, 16'd500, 16'd2);
        // disabled tick with every field at an extreme
        send_beat(tick(1'b0, 1'b1, 1'b1, 32767, -32768, -32768, 32767, 65535,
                       32'hFFFF_FFFF, 32767, 32767));
        // spin up, fire, then jam on torque with a stalled feeder
        send_beat(tick(1'b1, 1'b1, 1'b0, 1000, -1000, 1000, 0, 100, 32'd100, 1000, -32768));
        send_beat(tick(1'b1, 1'b1, 1'b0, 1000, -1000, 1000, 0, 100, 32'd110, 1000, -32768));
        send_beat(tick(1'b1, 1'b1, 1'b0, 1000, -1000, -49, 5001, 100, 32'd120, 1000, -32768));
        // unjam timeout must be strictly exceeded
        send_beat(tick(1'b1, 1'b1, 1'b0, 1000, -1000, 1000, 0, 100, 32'd320, 1000, -32768));
        send_beat(tick(1'b1, 1'b1, 1'b0, 1000, -1000, 1000, 0, 100, 32'd321, 1000, -32768));
        send_beat(tick(1'b1, 1'b1, 1'b0, 1000, -1000, 1000, 0, 100, 32'd330, 1000, 32767));
        // jam cleared early by reverse torque
        send_beat(tick(1'b1, 1'b1, 1'b0, 1000, -1000, 0, 32767, 100, 32'd340, 1000, 32767));
        send_beat(tick(1'b1, 1'b1, 1'b0, 1000, -1000, 0, -5001, 100, 32'd341, 1000, 32767));
        send_beat(tick(1'b1, 1'b1, 1'b0, 1000, -1000, 1000, 0, 100, 32'd350, 1000, 32767));
        // leaving firing needs both speed error and imbalance
        send_beat(tick(1'b1, 1'b1, 1'b0, 1200, -1200, 1000, 0, 100, 32'd360, 1000, 32767));
        send_beat(tick(1'b1, 1'b1, 1'b0, 1300, -700, 1000, 0, 100, 32'd370, 1000, 32767));
        // full-width imbalance of 65536
        send_beat(tick(1'b1, 1'b1, 1'b0, -32768, -32768, 1000, 0, 100, 32'd380, 1000, 32767));
        send_beat(tick(1'b1, 1'b1, 1'b0, 1000, -1000, 1000, 0, 100, 32'd390, 1000, 32767));
        // overheat, resume threshold strictly above heat_resume
        send_beat(tick(1'b1, 1'b1, 1'b0, 1000, -1000, 1000, 0, 0, 32'd400, 1000, 32767));
        send_beat(tick(1'b1, 1'b1, 1'b0, 1000, -1000, 1000, 0, 2, 32'd410, 1000, 32767));
        send_beat(tick(1'b1, 1'b1, 1'b0, 1000, -1000, 1000, 0, 3, 32'd420, 1000, 32767));
        send_beat(tick(1'b1, 1'b1, 1'b0, 1000, -1000, 1000, 0, 3, 32'd430, 1000, 32767));
        send_beat(tick(1'b1, 1'b1, 1'b0, 1000, -1000, 1000, 0, 0, 32'd440, 1000, 32767));
        // release fire near the time wrap; clearing times out across it
        send_beat(tick(1'b1, 1'b0, 1'b0, 1000, -1000, 1000, 0, 65535, 32'hFFFF_FF00,
                       32767, 0));
        send_beat(tick(1'b1, 1'b0, 1'b0, 1000, -1000, 1000, 0, 65535, 32'h0000_00F4,
                       32767, 0));
        send_beat(tick(1'b1, 1'b0, 1'b0, 1000, -1000, 1000, 0, 65535, 32'h0000_00F5,
                       32767, 0));
        // keep-spinning override alone, then fire from clearing
        send_beat(tick(1'b1, 1'b0, 1'b1, 1000, -1000, 1000, 0, 100, 32'h0000_0100, 0, 0));
        send_beat(tick(1'b1, 1'b0, 1'b0, 1000, -1000, 1000, 0, 100, 32'h0000_0110, 1000, 0));
        send_beat(tick(1'b1, 1'b1, 1'b0, 1000, -1000, 1000, 0, 100, 32'h0000_0120, 1000, 0));
        send_beat(tick(1'b1, 1'b1, 1'b0, 1000, -1000, 1000, 0, 100, 32'h0000_0130, 1000, -1));
        // fire dropped while feeding
        send_beat(tick(1'b1, 1'b0, 1'b0, 1000, -1000, 1000, 0, 100, 32'h0000_0140, 1000, -1));
        wait_results_settled();
    endtask

    task automatic test_default_settings();
        program_regs(16'(lsfj_pkg::RST_UNJAM_SPEED), 16'(lsfj_pkg::RST_SPEED_MARGIN),
                     16'(lsfj_pkg::RST_BALANCE_MARGIN), 16'(lsfj_pkg::RST_JAM_TORQUE),
                     16'(lsfj_pkg::RST_JAM_SPEED), lsfj_pkg::RST_UNJAM_MS,
                     lsfj_pkg::RST_CLEAR_MS, lsfj_pkg::RST_HEAT_RESUME);
        run_random_ticks(300, 0, 0, 1'b0);
    endtask

    task automatic test_low_extreme_settings();
        program_regs(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                     16'h0000);
        run_random_ticks(200, 65, 0, 1'b0);
    endtask

    task automatic test_high_extreme_settings();
        program_regs(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF);
        run_random_ticks(150, 0, 65, 1'b0);
    endtask

    task automatic test_random_settings();
        for (int k = 0; k < 2; k++)
        begin
            program_regs(16'($urandom), 16'($urandom_range(400)), 16'($urandom_range(400)),
                         16'($urandom_range(20000)), 16'($urandom_range(300)),
                         16'($urandom_range(400)), 16'($urandom_range(1000)),
                         16'($urandom_range(20)));
            if (k == 0)
                run_random_ticks(300, 8, 8, 1'b1);
            else
                run_random_ticks(300, 0, 0, 1'b0);
        end
    endtask

    // Receiver: stall at random per the current phase
    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic flag_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
        if (got !== want)
        begin
            n_errors++;
            if (n_errors <= 40)
                $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : check_results
        lsfj_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (due_setpoints.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 40)
                    $display("%0t ns: result beat with nothing expected, got %h",
                             $time, result_data);
            end
            else
            begin
                want = due_setpoints.pop_front();
                flag_field("left_setpoint", want.left_setpoint, result_data.left_setpoint);
                flag_field("right_setpoint", want.right_setpoint, result_data.right_setpoint);
                flag_field("feeder_setpoint", want.feeder_setpoint,
                           result_data.feeder_setpoint);
                flag_field("wheel_state", {30'd0, want.wheel_state},
                           {30'd0, result_data.wheel_state});
                flag_field("feed_state", {29'd0, want.feed_state},
                           {29'd0, result_data.feed_state});
                flag_field("clear_integral", {31'd0, want.clear_integral},
                           {31'd0, result_data.clear_integral});
                n_checked++;
                if (want.clear_integral)
                    n_jams++;
                if (want.feed_state == lsfj_pkg::FEED_OVERHEAT)
                    n_overheat++;
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_sequences();
        test_default_settings();
        test_low_extreme_settings();
        test_high_extreme_settings();
        test_random_settings();

        wait_results_settled();
        repeat (10) @(posedge clk);
        $display("Checked %0d of %0d ticks across %0d register settings and four idling mixes.",
                 n_checked, n_ticks, n_settings);
        $display("Saw %0d jam entries and %0d overheat ticks; %0d mismatches.",
                 n_jams, n_overheat, n_errors);
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[launcher_spinup_feed_jam_sequencer_core.f]
hdl/lsfj_pkg.sv
hdl/launcher_spinup_feed_jam_sequencer_core.sv
tb/sv/launcher_spinup_feed_jam_sequencer_core_test.sv
